>>> design/sdec_pkg.sv
// ----------------------------------------------------------------------------
// sdec_pkg: shared types and constants for signed integer to decimal text
// Holds the conversion work word, digit geometry, ASCII codes and the
// shift-and-add-3 step used by the BCD pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sdec_pkg;

	localparam int VALUE_W        = 32;
	localparam int DIGIT_W        = 4;
	localparam int NUM_DIGITS     = 10;
	localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
	localparam int BITS_PER_STAGE = 4;
	localparam int NUM_BCD_STAGES = VALUE_W / BITS_PER_STAGE;
	localparam int IDX_W          = $clog2(NUM_DIGITS);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef logic [IDX_W-1:0] sdec_idx_t;

	typedef struct packed {
		logic               neg;
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
	} sdec_work_t;

	// One double-dabble step: correct each digit, then shift one bit in.
	function automatic sdec_work_t sdec_dabble(input sdec_work_t w);
		sdec_work_t r;
		r = w;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (r.bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
				r.bcd[d*DIGIT_W +: DIGIT_W] = r.bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
			end
		end
		{r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
		return r;
	endfunction

endpackage

`default_nettype wire

>>> design/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Pipelined binary to BCD conversion followed by a one-character-per-cycle
// serializer that holds while stalled; the last character of each number is flagged.
// ----------------------------------------------------------------------------
// Each value transfer produces its decimal text on the output channel, one
// character per transfer, most significant first: a '-' for negative values,
// then the digits with leading zeros dropped (zero gives a single '0', and
// the most negative value gives "-2147483648"). last marks the final
// character. The first character follows the value transfer through the
// sign and magnitude register, eight shift-and-add-3 stages of four bits
// each, the register that finds the top nonzero digit, and the serializer
// load. A number has 1 to 11 characters, and the serializer drives one
// character per cycle while text_stall is low; this output port sets the
// sustained rate. Up to ten further values queue in the pipeline while the
// serializer is busy, and value_stall rises only once every stage holds an
// item.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii
	import sdec_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               value_valid,
	output logic                    value_stall,
	input  wire logic signed [31:0] value,
	output logic                    text_valid,
	input  wire logic               text_stall,
	output logic [7:0]              ch,
	output logic                    last
);

	// Sign and magnitude stage.
	logic               vld_s1;
	sdec_work_t         work_s1;
	logic               ready_s1;
	logic [VALUE_W-1:0] raw;
	logic [VALUE_W-1:0] mag;

	// Chain between BCD stages: index 0 is the front stage output.
	logic       stg_vld  [NUM_BCD_STAGES+1];
	sdec_work_t stg_work [NUM_BCD_STAGES+1];
	logic       stg_rdy  [NUM_BCD_STAGES+1];

	// Top-digit search stage.
	logic             vld_s10;
	logic             neg_s10;
	logic [BCD_W-1:0] bcd_s10;
	sdec_idx_t        top_s10;
	logic             ready_s10;
	sdec_idx_t        top_next;
	logic             ser_ready;

	// Form the magnitude in 32 bits unsigned: the most negative value maps
	// onto 2^31 without overflow.
	assign raw = $unsigned(value);
	assign mag = raw[VALUE_W-1] ? (~raw + 32'd1) : raw;

	assign ready_s1    = !vld_s1 || stg_rdy[0];
	assign value_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ready_s1) begin
			vld_s1 <= value_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && value_valid) begin
			work_s1.neg <= raw[VALUE_W-1];
			work_s1.bcd <= '0;
			work_s1.bin <= mag;
		end
	end

	assign stg_vld[0]  = vld_s1;
	assign stg_work[0] = work_s1;

	// Shift-and-add-3 pipeline, four magnitude bits per stage.
	for (genvar g = 0; g < NUM_BCD_STAGES; g++) begin : g_bcd
		sdec_bcd_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_vld[g]),
			.in_work   (stg_work[g]),
			.in_ready  (stg_rdy[g]),
			.out_valid (stg_vld[g+1]),
			.out_work  (stg_work[g+1]),
			.out_ready (stg_rdy[g+1])
		);
	end

	// Find the highest nonzero digit; an all-zero number keeps digit 0.
	always_comb begin
		top_next = '0;
		for (int d = 1; d < NUM_DIGITS; d++) begin
			if (stg_work[NUM_BCD_STAGES].bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
				top_next = IDX_W'(d);
			end
		end
	end

	assign ready_s10               = !vld_s10 || ser_ready;
	assign stg_rdy[NUM_BCD_STAGES] = ready_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (ready_s10) begin
			vld_s10 <= stg_vld[NUM_BCD_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s10 && stg_vld[NUM_BCD_STAGES]) begin
			neg_s10 <= stg_work[NUM_BCD_STAGES].neg;
			bcd_s10 <= stg_work[NUM_BCD_STAGES].bcd;
			top_s10 <= top_next;
		end
	end

	// Drive characters, one transfer per cycle while not stalled.
	sdec_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s10),
		.in_neg    (neg_s10),
		.in_bcd    (bcd_s10),
		.in_top    (top_s10),
		.in_ready  (ser_ready),
		.out_valid (text_valid),
		.out_ch    (ch),
		.out_last  (last),
		.out_stall (text_stall)
	);

	// A number's text continues without a gap once started.
	a_text_continues: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_stall && !last |=> text_valid)
		else $error("text ended before its last character");

	// The minus sign always has digits after it.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && (ch == CH_MINUS) |-> !last)
		else $error("minus sign flagged as last character");

	// An empty front stage always takes a value.
	a_front_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> !value_stall)
		else $error("value stalled with an empty front stage");

endmodule

`default_nettype wire

>>> design/sdec_bcd_stage.sv
// ----------------------------------------------------------------------------
// sdec_bcd_stage: one register stage of the binary to BCD pipeline
// Shifts BITS_PER_STAGE magnitude bits into the BCD digits, holding on stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sdec_bcd_stage
	import sdec_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire sdec_work_t in_work,
	output logic            in_ready,
	output logic            out_valid,
	output sdec_work_t      out_work,
	input  wire logic       out_ready
);

	logic       vld_s1;
	sdec_work_t work_s1;
	sdec_work_t work_next;

	always_comb begin
		work_next = in_work;
		for (int b = 0; b < BITS_PER_STAGE; b++) begin
			work_next = sdec_dabble(work_next);
		end
	end

	// Take a new item whenever the stage is empty or drains this cycle.
	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_s1 <= work_next;
		end
	end

	assign out_valid = vld_s1;
	assign out_work  = work_s1;

endmodule

`default_nettype wire

>>> design/sdec_serializer.sv
// ----------------------------------------------------------------------------
// sdec_serializer: character output stage
// Emits the optional minus sign, then digits from the top nonzero one down.
// ----------------------------------------------------------------------------
`default_nettype none

module sdec_serializer
	import sdec_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_neg,
	input  wire logic [BCD_W-1:0] in_bcd,
	input  wire sdec_idx_t        in_top,
	output logic                  in_ready,
	output logic                  out_valid,
	output logic [7:0]            out_ch,
	output logic                  out_last,
	input  wire logic             out_stall
);

	logic             busy_q;
	logic             minus_q;
	sdec_idx_t        idx_q;
	logic [BCD_W-1:0] bcd_q;
	logic [DIGIT_W-1:0] digit;
	logic             final_char;

	assign digit      = bcd_q[idx_q*DIGIT_W +: DIGIT_W];
	assign final_char = !minus_q && (idx_q == '0);

	// Load the next number as the last character of this one transfers.
	assign in_ready = !busy_q || (!out_stall && final_char);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			minus_q <= 1'b0;
			idx_q   <= '0;
		end else if (in_ready) begin
			busy_q <= in_valid;
			if (in_valid) begin
				minus_q <= in_neg;
				idx_q   <= in_top;
			end
		end else if (busy_q && !out_stall) begin
			if (minus_q) begin
				minus_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bcd_q <= in_bcd;
		end
	end

	assign out_valid = busy_q;
	assign out_ch    = minus_q ? CH_MINUS : (CH_ZERO + {4'b0000, digit});
	assign out_last  = final_char;

endmodule

`default_nettype wire

>>> sim/signed_int_to_decimal_ascii_tb.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb: self-checking bench for the decimal text unit
// Feeds signed 32-bit values (directed corner values, then random values of
// every digit count), predicts the ASCII text of each accepted value, and
// compares every character transfer against it under random idling and
// stalling, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_tb
	import sdec_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Run shape
	localparam int RANDOM_ITEMS   = 200;
	localparam int SEND_CALM_LO   = 40;    // sender never idles for these items
	localparam int SEND_CALM_HI   = 100;
	localparam int HOLD_AT        = 45;    // start the long output hold-off here
	localparam int HOLD_CYCLES    = 400;
	localparam int PAUSE_AT       = 150;   // sender waits for a full drain here
	localparam int RECV_CALM_LO   = 900;   // receiver never stalls for these chars
	localparam int RECV_CALM_HI   = 1300;
	localparam int IDLE_PERCENT   = 28;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               value_valid = 1'b0;
	logic signed [31:0] value       = '0;
	logic               text_stall  = 1'b0;
	logic               value_stall;
	logic               text_valid;
	logic [7:0]         ch;
	logic               last;

	logic signed [31:0] pending_values[$];
	text_char_t         expected_text[$];

	int items_sent;
	int chars_seen;
	int mismatches;
	int quiet_cycles;

	signed_int_to_decimal_ascii dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.ch          (ch),
		.last        (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Build the expected text of one value: optional minus, then the digits
	// most significant first, last set on the final character. The magnitude
	// is taken at 33 bits so the most negative value needs no special path.
	function automatic void predict_text(input logic [31:0] v);
		logic [32:0] mag;
		logic [7:0]  digits[10];
		int          nd;
		mag = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
		nd  = 0;
		do begin
			digits[nd] = CH_ZERO + 8'(mag % 10);
			mag        = mag / 10;
			nd++;
		end while (mag != 0);
		if (v[31]) begin
			expected_text.push_back('{ch: CH_MINUS, last: 1'b0});
		end
		for (int i = nd - 1; i >= 0; i--) begin
			expected_text.push_back('{ch: digits[i], last: (i == 0)});
		end
	endfunction

	// Pick a digit count first so short and long texts both show up often;
	// the ten-digit case draws a full random word and so hits every bit.
	function automatic logic signed [31:0] random_value();
		logic [63:0] span;
		logic [31:0] mag;
		int          ndig;
		ndig = $urandom_range(1, 10);
		if (ndig == 10) begin
			return $urandom;
		end
		span = 1;
		for (int k = 0; k < ndig; k++) begin
			span = span * 10;
		end
		mag = 32'({32'd0, $urandom} % span);
		return ($urandom_range(0, 1) != 0) ? -mag : mag;
	endfunction

	// Driver: present the next pending value, hold it while stalled, and
	// record the prediction on every value transfer.
	always @(posedge clk or negedge arst_n) begin : drive_values
		int  n_sent;
		logic idle;
		if (!arst_n) begin
			value_valid <= 1'b0;
			value       <= '0;
			items_sent  <= 0;
		end else begin
			n_sent = items_sent;
			if (value_valid && !value_stall) begin
				predict_text(value);
				n_sent = n_sent + 1;
			end
			items_sent <= n_sent;
			if (!value_valid || !value_stall) begin
				// Keep offering during the calm window so the hold-off fills
				// the pipeline; elsewhere idle at random.
				if (n_sent >= SEND_CALM_LO && n_sent < SEND_CALM_HI) begin
					idle = 1'b0;
				end else begin
					idle = ($urandom_range(0, 99) < IDLE_PERCENT);
				end
				// Hold back until every expected character has arrived.
				if (n_sent == PAUSE_AT && expected_text.size() != 0) begin
					idle = 1'b1;
				end
				if (!idle && pending_values.size() != 0) begin
					value       <= pending_values.pop_front();
					value_valid <= 1'b1;
				end else begin
					value_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each character transfer against the oldest expectation,
	// then choose the stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin : check_text
		text_char_t want;
		int         n_seen;
		int         hold_left;
		logic       hold_done;
		if (!arst_n) begin
			text_stall <= 1'b0;
			chars_seen <= 0;
			mismatches  = 0;
			hold_left   = 0;
			hold_done   = 1'b0;
		end else begin
			n_seen = chars_seen;
			if (text_valid && !text_stall) begin
				n_seen = n_seen + 1;
				if (expected_text.size() == 0) begin
					$display("%0t: unexpected char: expected none, actual ch %h last %b",
						$time, ch, last);
					mismatches++;
				end else begin
					want = expected_text.pop_front();
					if (ch !== want.ch) begin
						$display("%0t: ch mismatch: expected %h, actual %h",
							$time, want.ch, ch);
						mismatches++;
					end
					if (last !== want.last) begin
						$display("%0t: last mismatch: expected %b, actual %b",
							$time, want.last, last);
						mismatches++;
					end
				end
			end
			chars_seen <= n_seen;
			// Drop the long hold-off once, while the sender keeps pushing.
			if (!hold_done && items_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				text_stall <= 1'b1;
			end else if (n_seen >= RECV_CALM_LO && n_seen < RECV_CALM_HI) begin
				text_stall <= 1'b0;
			end else begin
				text_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
			end
		end
	end

	// Count cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((value_valid && !value_stall) || (text_valid && !text_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		// Directed corners: zero, single digits, decade edges, both extremes,
		// the most negative value and alternating bit patterns.
		pending_values.push_back(32'sd0);
		pending_values.push_back(32'sd1);
		pending_values.push_back(-32'sd1);
		pending_values.push_back(32'sd9);
		pending_values.push_back(32'sd10);
		pending_values.push_back(-32'sd10);
		pending_values.push_back(32'sd99);
		pending_values.push_back(32'sd100);
		pending_values.push_back(-32'sd9);
		pending_values.push_back(32'sd2147483647);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(-32'sd2147483647);
		pending_values.push_back(32'sd1000000000);
		pending_values.push_back(32'sd999999999);
		pending_values.push_back(-32'sd999999999);
		pending_values.push_back(-32'sd1000000000);
		pending_values.push_back(32'sd123456789);
		pending_values.push_back(32'h5555_5555);
		pending_values.push_back(32'hAAAA_AAAA);
		pending_values.push_back(32'sd0);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pending_values.push_back(random_value());
		end

		// Hold reset, then release it away from the rising edge.
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Advance until all values are in and every character is back.
		while (pending_values.size() != 0 || value_valid || expected_text.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
